FILE: rtl/gcda_pkg.sv
// Shared constants for the Geiger CPM averager: field widths, register
// indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gcda_pkg;

  // Result field widths
  localparam int unsigned RawW   = 22;
  localparam int unsigned CompW  = 23;
  localparam int unsigned C5OutW = 19;
  localparam int unsigned TotW   = 40;

  // Dead-time coefficient, Q0.32
  localparam int unsigned CoeffW = 16;
  localparam int unsigned FracW  = 32;

  // Configuration port
  localparam int unsigned CfgDataW = 23;
  localparam int unsigned CfgIdxW  = 2;
  localparam logic [CfgIdxW-1:0] CfgIdxThr   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxCoeff = 2'd1;

  localparam logic [CompW-1:0]  ThrReset   = 23'h7F_FFFF;
  localparam logic [CoeffW-1:0] CoeffReset = 16'd8089;

  // Length of the short sum, in bins
  localparam int unsigned C5Len = 5;

endpackage

`default_nettype wire

FILE: rtl/gcda_req_if.sv
// Request channel of the CPM averager: one per-second pulse count.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface gcda_req_if #(
  parameter int unsigned COUNT_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] pulse_count;

  modport source (output valid, output pulse_count, input ready);
  modport sink   (input valid, input pulse_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/gcda_res_if.sv
// Result channel of the CPM averager.
// Depends on gcda_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gcda_res_if;
  logic                          valid;
  logic                          ready;
  logic [gcda_pkg::RawW-1:0]     cpm_raw;
  logic [gcda_pkg::CompW-1:0]    cpm_corr;
  logic [gcda_pkg::CompW-1:0]    cpm_peak;
  logic [gcda_pkg::C5OutW-1:0]   count_5s;
  logic [gcda_pkg::TotW-1:0]     total_count;
  logic                          window_full;
  logic                          alert;
  logic                          alert_rising;

  modport source (output valid, output cpm_raw, output cpm_corr, output cpm_peak,
                  output count_5s, output total_count, output window_full,
                  output alert, output alert_rising, input ready);
  modport sink   (input valid, input cpm_raw, input cpm_corr, input cpm_peak,
                  input count_5s, input total_count, input window_full,
                  input alert, input alert_rising, output ready);
endinterface

`default_nettype wire

FILE: rtl/geiger_cpm_deadtime_averager_unit.sv
// Geiger CPM averager. Each accepted request is one per-second pulse count;
// a zero count is dropped, with no result, until the first nonzero count has
// arrived. Every other request yields one result: the one-minute ring sum, the
// five-second sum, the running 40-bit total, and the CPM scaled for a partly
// filled window and corrected for dead time as eff / (1 - eff*K) while that
// factor stays above 0.1, with peak and alert tracking. Most of a request's
// work is done in the 23-step serial divider, which stops early when the
// result saturates; one request is processed at a time, and the next is
// taken while a finished result waits in the output register.
// The ring lives in one memory read at two addresses and written once per
// request; it needs no clearing pass after reset.
// Depends on gcda_pkg, gcda_req_if, gcda_res_if, gcda_ring and gcda_div.
`timescale 1ns / 1ps
`default_nettype none

module geiger_cpm_deadtime_averager_unit #(
  parameter int unsigned WINDOW_BINS = 60,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  gcda_req_if.sink                                 req_i,
  gcda_res_if.source                               res_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [gcda_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [gcda_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned LW    = $clog2(WINDOW_BINS + 1);
  localparam int unsigned SW    = COUNT_WIDTH + $clog2(WINDOW_BINS);
  localparam int unsigned C5W   = COUNT_WIDTH + 3;
  localparam int unsigned NW    = SW + $clog2(WINDOW_BINS);
  localparam int unsigned PW    = NW + gcda_pkg::CoeffW;
  localparam int unsigned DQW   = LW + gcda_pkg::FracW;
  localparam int unsigned CMPW  = ((PW > DQW) ? PW : DQW) + 1;
  localparam int unsigned TW    = DQW + 4;
  localparam int unsigned XW    = NW + gcda_pkg::FracW;
  localparam int unsigned QW    = gcda_pkg::CompW;
  localparam int unsigned RawMW = (SW > gcda_pkg::RawW) ? SW : gcda_pkg::RawW;
  localparam int unsigned C5MW  = (C5W > gcda_pkg::C5OutW) ? C5W : gcda_pkg::C5OutW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_SCALE = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_START = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [QW-1:0]                  thr_q;
  logic [gcda_pkg::CoeffW-1:0]    coeff_q;
  logic [gcda_pkg::TotW-1:0]      total_q;
  logic [QW-1:0]                  peak_q;
  logic                           prev_alert_q;

  logic [NW-1:0]                  n_q;
  logic [LW-1:0]                  d_q;
  logic [PW-1:0]                  k_q;
  logic                           lt_q;
  logic [DQW-1:0]                 den_q;

  logic                           out_valid_q;
  logic [gcda_pkg::RawW-1:0]      raw_q;
  logic [QW-1:0]                  comp_q;
  logic [QW-1:0]                  peak_out_q;
  logic [gcda_pkg::C5OutW-1:0]    c5_q;
  logic [gcda_pkg::TotW-1:0]      total_out_q;
  logic                           full_q;
  logic                           alert_q;
  logic                           rising_q;

  logic                           accept;
  logic                           push;
  logic [SW-1:0]                  ring_sum;
  logic [C5W-1:0]                 ring_c5;
  logic [LW-1:0]                  ring_samples;
  logic                           ring_full;

  logic [DQW-1:0]                 dq;
  logic [CMPW-1:0]                den_wide;
  logic [TW-1:0]                  den_x10;
  logic                           use_comp;
  logic                           div_start;
  logic [XW-1:0]                  div_x;
  logic [DQW-1:0]                 div_y;
  logic                           div_done;
  logic [QW-1:0]                  div_q;

  logic                           load_out;
  logic                           alert_n;
  logic [QW-1:0]                  peak_n;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  // Drop leading zero counts before the first sample
  assign push        = accept && !((req_i.pulse_count == '0) && (ring_samples == '0));

  gcda_ring #(
    .WINDOW_BINS (WINDOW_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .count_i   (req_i.pulse_count),
    .sum_o     (ring_sum),
    .c5_o      (ring_c5),
    .samples_o (ring_samples),
    .full_o    (ring_full)
  );

  assign dq       = {d_q, {gcda_pkg::FracW{1'b0}}};
  assign den_wide = CMPW'(dq) - CMPW'(k_q);
  assign den_x10  = (TW'(den_q) << 3) + (TW'(den_q) << 1);
  assign use_comp = lt_q && (den_x10 > TW'(dq));

  assign div_start = (state_q == S_START);
  assign div_x     = use_comp ? {n_q, {gcda_pkg::FracW{1'b0}}} : XW'(n_q);
  assign div_y     = use_comp ? den_q : DQW'(d_q);

  gcda_div #(
    .XW (XW),
    .YW (DQW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .y_i     (div_y),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign load_out = (state_q == S_FIN) && (!out_valid_q || res_o.ready);
  assign alert_n  = (div_q > thr_q);
  assign peak_n   = (div_q > peak_q) ? div_q : peak_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (push) state_d = S_READ;
      S_READ:  state_d = S_SCALE;
      S_SCALE: state_d = S_MUL;
      S_MUL:   state_d = S_CHECK;
      S_CHECK: state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_FIN;
      S_FIN:   if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thr_q        <= gcda_pkg::ThrReset;
      coeff_q      <= gcda_pkg::CoeffReset;
      total_q      <= '0;
      peak_q       <= '0;
      prev_alert_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == gcda_pkg::CfgIdxThr) begin
          thr_q <= cfg_data_i[QW-1:0];
        end else if (cfg_idx_i == gcda_pkg::CfgIdxCoeff) begin
          coeff_q <= cfg_data_i[gcda_pkg::CoeffW-1:0];
        end
      end
      if (push) begin
        total_q <= total_q + gcda_pkg::TotW'(req_i.pulse_count);
      end
      if (load_out) begin
        peak_q       <= peak_n;
        prev_alert_q <= alert_n;
        out_valid_q  <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: scale, multiply by K, form the denominator, load the result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCALE) begin
      n_q <= ring_full ? NW'(ring_sum) : NW'(ring_sum) * NW'(WINDOW_BINS);
      d_q <= ring_full ? LW'(1) : ring_samples;
    end
    if (state_q == S_MUL) begin
      k_q <= PW'(n_q) * PW'(coeff_q);
    end
    if (state_q == S_CHECK) begin
      lt_q  <= (CMPW'(k_q) < CMPW'(dq));
      den_q <= den_wide[DQW-1:0];
    end
    if (load_out) begin
      raw_q       <= (RawMW'(ring_sum) > RawMW'({gcda_pkg::RawW{1'b1}}))
                     ? {gcda_pkg::RawW{1'b1}} : gcda_pkg::RawW'(RawMW'(ring_sum));
      c5_q        <= (C5MW'(ring_c5) > C5MW'({gcda_pkg::C5OutW{1'b1}}))
                     ? {gcda_pkg::C5OutW{1'b1}} : gcda_pkg::C5OutW'(C5MW'(ring_c5));
      comp_q      <= div_q;
      peak_out_q  <= peak_n;
      total_out_q <= total_q;
      full_q      <= ring_full;
      alert_q     <= alert_n;
      rising_q    <= alert_n && !prev_alert_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.cpm_raw      = raw_q;
  assign res_o.cpm_corr     = comp_q;
  assign res_o.cpm_peak     = peak_out_q;
  assign res_o.count_5s     = c5_q;
  assign res_o.total_count  = total_out_q;
  assign res_o.window_full  = full_q;
  assign res_o.alert        = alert_q;
  assign res_o.alert_rising = rising_q;

  a_peak_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> peak_q >= $past(peak_q))
    else $error("peak decreased");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_i.ready)
    else $error("request taken while busy");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside finish step");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide step");

  a_rising_implies_alert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(rising_q && !alert_q))
    else $error("alert edge without alert");

endmodule

`default_nettype wire

FILE: rtl/gcda_ring.sv
// Count ring of the CPM averager: one-minute bin memory with running window
// and five-second sums, updated by read-modify-write. Depends on gcda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcda_ring #(
  parameter int unsigned WINDOW_BINS = 60,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          push_i,
  input  wire logic [COUNT_WIDTH-1:0]                        count_i,
  output logic [COUNT_WIDTH+$clog2(WINDOW_BINS)-1:0]         sum_o,
  output logic [COUNT_WIDTH+2:0]                             c5_o,
  output logic [$clog2(WINDOW_BINS+1)-1:0]                   samples_o,
  output logic                                               full_o
);

  localparam int unsigned AW  = $clog2(WINDOW_BINS);
  localparam int unsigned LW  = $clog2(WINDOW_BINS+1);
  localparam int unsigned SW  = COUNT_WIDTH + $clog2(WINDOW_BINS);
  localparam int unsigned C5W = COUNT_WIDTH + 3;
  localparam int unsigned Lag = gcda_pkg::C5Len;

  logic [COUNT_WIDTH-1:0] mem [WINDOW_BINS];

  logic [AW-1:0]          wp_q;
  logic [LW-1:0]          samples_q;
  logic [SW-1:0]          sum_q;
  logic [C5W-1:0]         c5_q;
  logic                   upd_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [COUNT_WIDTH-1:0] rd_a_q;
  logic [COUNT_WIDTH-1:0] rd_b_q;

  logic [AW-1:0]          lag_addr;
  logic                   full;
  logic [COUNT_WIDTH-1:0] old_a;
  logic [COUNT_WIDTH-1:0] old_b;

  // Bin written five requests ago
  always_comb begin
    if (wp_q >= AW'(Lag)) begin
      lag_addr = wp_q - AW'(Lag);
    end else begin
      lag_addr = AW'((AW+1)'(wp_q) + (AW+1)'(WINDOW_BINS - Lag));
    end
  end

  assign full = (samples_q == LW'(WINDOW_BINS));

  // Bins not yet written read as zero: drop stale memory contents by fill count
  assign old_a = full ? rd_a_q : '0;
  assign old_b = (samples_q >= LW'(Lag)) ? rd_b_q : '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rd_a_q <= mem[wp_q];
      rd_b_q <= mem[lag_addr];
      cnt_q  <= count_i;
    end
    if (upd_q) begin
      mem[wp_q] <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q     <= 1'b0;
      wp_q      <= '0;
      samples_q <= '0;
      sum_q     <= '0;
      c5_q      <= '0;
    end else begin
      upd_q <= push_i;
      if (upd_q) begin
        sum_q <= sum_q - SW'(old_a) + SW'(cnt_q);
        c5_q  <= c5_q - C5W'(old_b) + C5W'(cnt_q);
        wp_q  <= (wp_q == AW'(WINDOW_BINS - 1)) ? '0 : wp_q + AW'(1);
        if (!full) begin
          samples_q <= samples_q + LW'(1);
        end
      end
    end
  end

  assign sum_o     = sum_q;
  assign c5_o      = c5_q;
  assign samples_o = samples_q;
  assign full_o    = full;

endmodule

`default_nettype wire

FILE: rtl/gcda_div.sv
// Restoring divider of the CPM averager: one quotient bit per cycle, result
// saturated to the compensated CPM width. Depends on gcda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcda_div #(
  parameter int unsigned XW = 80,
  parameter int unsigned YW = 41
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [XW-1:0]                x_i,
  input  wire logic [YW-1:0]                y_i,
  output logic                              done_o,
  output logic [gcda_pkg::CompW-1:0]        q_o
);

  localparam int unsigned QW   = gcda_pkg::CompW;
  localparam int unsigned HW   = XW - QW;
  localparam int unsigned MW   = (HW > YW) ? HW : YW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic            chk_q;
  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [HW-1:0]   x_hi_q;
  logic [QW-1:0]   low_q;
  logic [YW-1:0]   y_q;
  logic [YW-1:0]   rem_q;
  logic [QW-1:0]   q_q;

  logic            ovf;
  logic [YW:0]     rem2;
  logic            ge;

  // Quotient would not fit when the high part already reaches the divisor
  assign ovf  = (MW'(x_hi_q) >= MW'(y_q));
  assign rem2 = {rem_q, low_q[QW-1]};
  assign ge   = (rem2 >= {1'b0, y_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q  <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      chk_q  <= start_i;
      if (chk_q) begin
        if (ovf) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CntW'(QW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_hi_q <= x_i[XW-1:QW];
      low_q  <= x_i[QW-1:0];
      y_q    <= y_i;
    end else if (chk_q) begin
      rem_q <= MW'(x_hi_q) >> 0 == '0 ? '0 : YW'(MW'(x_hi_q));
      if (ovf) begin
        q_q <= '1;
      end else begin
        q_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= ge ? YW'(rem2 - {1'b0, y_q}) : YW'(rem2);
      q_q   <= {q_q[QW-2:0], ge};
      low_q <= {low_q[QW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

`default_nettype wire

FILE: dv/geiger_cpm_deadtime_averager_unit_tb.sv
// Self-checking bench for geiger_cpm_deadtime_averager_unit: random and directed
// pulse counts, a transaction-level CPM predictor and an in-order result scoreboard.
// Depends on gcda_pkg, gcda_req_if, gcda_res_if and the unit itself.
`timescale 1ns / 1ps

module geiger_cpm_deadtime_averager_unit_tb;

  localparam int unsigned WinBins     = 60;
  localparam int unsigned CountW      = 16;
  localparam int unsigned IdlePct     = 24;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 122;
  localparam longint unsigned RawMax  = (64'd1 << gcda_pkg::RawW) - 1;
  localparam longint unsigned CompMax = (64'd1 << gcda_pkg::CompW) - 1;
  localparam longint unsigned C5Max   = (64'd1 << gcda_pkg::C5OutW) - 1;
  localparam logic [gcda_pkg::CfgIdxW-1:0] IdxSpareLo = 2'd2;
  localparam logic [gcda_pkg::CfgIdxW-1:0] IdxSpareHi = 2'd3;

  typedef struct packed {
    logic [gcda_pkg::RawW-1:0]   raw;
    logic [gcda_pkg::CompW-1:0]  comp;
    logic [gcda_pkg::CompW-1:0]  peak;
    logic [gcda_pkg::C5OutW-1:0] c5;
    logic [gcda_pkg::TotW-1:0]   total;
    logic                        full;
    logic                        alert;
    logic                        rising;
  } cpm_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [gcda_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [gcda_pkg::CfgDataW-1:0] cfg_data;

  gcda_req_if #(.COUNT_WIDTH(CountW)) req_ch ();
  gcda_res_if res_ch ();

  geiger_cpm_deadtime_averager_unit #(
    .WINDOW_BINS(WinBins),
    .COUNT_WIDTH(CountW)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .res_o     (res_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Predictor state
  logic [CountW-1:0]           minute_ring [WinBins];
  int unsigned                 ring_pos;
  int unsigned                 samples_in;
  logic [gcda_pkg::TotW-1:0]   pulse_total;
  logic [gcda_pkg::CompW-1:0]  peak_comp;
  logic [gcda_pkg::CompW-1:0]  last_comp;
  bit                          alert_was;
  logic [gcda_pkg::CompW-1:0]  thr_cfg;
  logic [gcda_pkg::CoeffW-1:0] coeff_cfg;

  cpm_result_t       cpm_expected_q [$];
  logic [CountW-1:0] count_backlog [$];

  bit steady;
  int unsigned queued_count, sent_count, accepted_count;
  int unsigned mismatches, results_seen, dropped_zeros, alert_onsets, saturated, cfg_writes;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic predict_minute(input logic [CountW-1:0] cnt);
    cpm_result_t r;
    longint unsigned sum, c5, n, d, prod, scale, comp;
    int unsigned i;
    if (cnt == 0 && samples_in == 0) begin
      dropped_zeros++;
      return;
    end
    pulse_total = pulse_total + gcda_pkg::TotW'(cnt);
    minute_ring[ring_pos] = cnt;
    c5 = 0;
    for (i = 0; i < gcda_pkg::C5Len; i++)
      c5 += minute_ring[(ring_pos + WinBins - i) % WinBins];
    ring_pos = (ring_pos + 1) % WinBins;
    if (samples_in < WinBins) samples_in++;
    sum = 0;
    for (i = 0; i < WinBins; i++) sum += minute_ring[i];
    if (samples_in >= WinBins) begin
      n = sum;
      d = 1;
    end else begin
      n = sum * WinBins;
      d = samples_in;
    end
    // dead-time correction only while 1 - eff*K stays above 0.1
    prod  = n * coeff_cfg;
    scale = d << gcda_pkg::FracW;
    if (prod < scale && 10 * (scale - prod) > scale)
      comp = (n << gcda_pkg::FracW) / (scale - prod);
    else comp = n / d;
    if (comp > CompMax) comp = CompMax;
    if (comp > peak_comp) peak_comp = gcda_pkg::CompW'(comp);
    last_comp = gcda_pkg::CompW'(comp);
    r.raw    = gcda_pkg::RawW'((sum > RawMax) ? RawMax : sum);
    r.comp   = gcda_pkg::CompW'(comp);
    r.peak   = peak_comp;
    r.c5     = gcda_pkg::C5OutW'((c5 > C5Max) ? C5Max : c5);
    r.total  = pulse_total;
    r.full   = (samples_in >= WinBins);
    r.alert  = (gcda_pkg::CompW'(comp) > thr_cfg);
    r.rising = r.alert && !alert_was;
    alert_was = r.alert;
    cpm_expected_q.push_back(r);
  endtask

  task automatic check_field(input string label, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    cpm_result_t w;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (cpm_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cpm_corr %0d",
                   $time, res_ch.cpm_corr);
          mismatches++;
        end else begin
          w = cpm_expected_q.pop_front();
          check_field("cpm_raw", w.raw, res_ch.cpm_raw);
          check_field("cpm_corr", w.comp, res_ch.cpm_corr);
          check_field("cpm_peak", w.peak, res_ch.cpm_peak);
          check_field("count_5s", w.c5, res_ch.count_5s);
          check_field("total_count", w.total, res_ch.total_count);
          check_field("window_full", w.full, res_ch.window_full);
          check_field("alert", w.alert, res_ch.alert);
          check_field("alert_rising", w.rising, res_ch.alert_rising);
          if (w.rising) alert_onsets++;
          if (w.comp == gcda_pkg::CompW'(CompMax)) saturated++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        accepted_count++;
        predict_minute(req_ch.pulse_count);
      end
    end
  end

  // Drive requests and result back-pressure at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (sent_count == accepted_count) begin
      if (count_backlog.size() > 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
        req_ch.valid       <= 1'b1;
        req_ch.pulse_count <= count_backlog.pop_front();
        sent_count++;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d results still due", $time, cpm_expected_q.size());
      $display("geiger_cpm_deadtime_averager_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic program_reg(input logic [gcda_pkg::CfgIdxW-1:0] idx,
                             input logic [gcda_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      gcda_pkg::CfgIdxThr:   thr_cfg = data[gcda_pkg::CompW-1:0];
      gcda_pkg::CfgIdxCoeff: coeff_cfg = data[gcda_pkg::CoeffW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_count(input logic [CountW-1:0] cnt);
    count_backlog.push_back(cnt);
    queued_count++;
  endtask

  // Hold until every request is taken and every result is back, then let
  // the unit settle.
  task automatic wait_drained();
    while (!(accepted_count == queued_count && cpm_expected_q.size() == 0))
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [CountW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? '1 : CountW'(1);
      2, 3:    return CountW'($urandom_range(0, 65535));
      4, 5, 6: return CountW'($urandom_range(0, 300));
      default: return CountW'($urandom_range(0, 20000));
    endcase
  endfunction

  // Alternate loud and quiet stretches so the alert keeps crossing
  function automatic logic [CountW-1:0] burst_count(input int unsigned k);
    if ((k / 8) % 2) return CountW'($urandom_range(20000, 65535));
    return CountW'($urandom_range(0, 50));
  endfunction

  function automatic logic [gcda_pkg::CfgDataW-1:0] near_threshold();
    int t;
    t = int'(last_comp) + int'($urandom_range(0, 40000)) - 20000;
    if (t < 0) t = 0;
    if (t > int'(CompMax)) t = int'(CompMax);
    return gcda_pkg::CfgDataW'(t);
  endfunction

  initial begin
    logic [CountW-1:0] directed [] = '{16'd0, 16'd0, 16'd15930, 16'd0, 16'd1, 16'hFFFF,
                                       16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                       16'h8000, 16'h5555, 16'hAAAA, 16'd1, 16'd2,
                                       16'hFFFF, 16'h00FF, 16'hFF00};
    int phase, k;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    req_ch.valid       = 1'b0;
    req_ch.pulse_count = '0;
    res_ch.ready       = 1'b0;
    steady = 1'b0;
    for (k = 0; k < WinBins; k++) minute_ring[k] = '0;
    ring_pos = 0; samples_in = 0; pulse_total = '0; peak_comp = '0; last_comp = '0;
    alert_was = 1'b0; thr_cfg = gcda_pkg::ThrReset; coeff_cfg = gcda_pkg::CoeffReset;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Small K and a mid threshold: the first loud second saturates and alerts
    program_reg(gcda_pkg::CfgIdxCoeff, {7'h7F, 16'd4000});
    program_reg(gcda_pkg::CfgIdxThr, gcda_pkg::CfgDataW'(1000000));
    program_reg(IdxSpareLo, gcda_pkg::CfgDataW'($urandom));
    program_reg(IdxSpareHi, gcda_pkg::CfgDataW'($urandom));
    foreach (directed[i]) queue_count(directed[i]);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          program_reg(gcda_pkg::CfgIdxThr, '1);
          program_reg(gcda_pkg::CfgIdxCoeff, '0);
        end
        1: begin
          program_reg(gcda_pkg::CfgIdxThr, '0);
          program_reg(gcda_pkg::CfgIdxCoeff, gcda_pkg::CfgDataW'(16'hFFFF));
        end
        2: begin
          program_reg(gcda_pkg::CfgIdxThr, near_threshold());
          program_reg(gcda_pkg::CfgIdxCoeff, gcda_pkg::CfgDataW'(gcda_pkg::CoeffReset));
        end
        3: begin
          program_reg(gcda_pkg::CfgIdxThr, near_threshold());
          program_reg(gcda_pkg::CfgIdxCoeff, gcda_pkg::CfgDataW'($urandom_range(0, 4600)));
        end
        6: begin
          program_reg(IdxSpareHi, gcda_pkg::CfgDataW'($urandom));
          program_reg(gcda_pkg::CfgIdxThr, near_threshold());
          program_reg(gcda_pkg::CfgIdxCoeff, gcda_pkg::CfgDataW'($urandom));
        end
        7: begin
          program_reg(gcda_pkg::CfgIdxThr, gcda_pkg::CfgDataW'($urandom));
          program_reg(gcda_pkg::CfgIdxCoeff, gcda_pkg::CfgDataW'($urandom));
        end
        default: begin
          program_reg(gcda_pkg::CfgIdxThr, near_threshold());
          program_reg(gcda_pkg::CfgIdxCoeff, gcda_pkg::CfgDataW'($urandom_range(0, 65535)));
        end
      endcase
      steady = (phase == 4);
      for (k = 0; k < PhaseItems; k++) begin
        if (phase == 2 || phase == 5 || phase == 7) queue_count(burst_count(k));
        else queue_count(pick_count());
      end
      wait_drained();
    end

    mismatches += cpm_expected_q.size();
    $display("Covered %0d requests (%0d leading zeros dropped), %0d results checked.",
             accepted_count, dropped_zeros, results_seen);
    $display("Saw %0d alert onsets and %0d saturated CPM values over %0d register writes.",
             alert_onsets, saturated, cfg_writes);
    if (mismatches == 0) begin
      $display("geiger_cpm_deadtime_averager_unit_tb: done, clean");
    end else begin
      $display("geiger_cpm_deadtime_averager_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
